// ===== rtl/core/ggfq_pkg.sv =====
package ggfq_pkg;

   localparam int MaxDepth = 16;
   localparam int PtrW = $clog2(MaxDepth);
   localparam int CntW = $clog2(MaxDepth + 1);
   localparam int SlotW = 32 + 47 + 32;

   localparam logic [2:0] K_SUBMIT = 3'd0;
   localparam logic [2:0] K_SETGEN = 3'd1;
   localparam logic [2:0] K_TAKE = 3'd2;
   localparam logic [2:0] K_SHOWN = 3'd3;
   localparam logic [2:0] K_CLEAR = 3'd4;
   localparam logic [2:0] K_STOP = 3'd5;
   localparam logic [2:0] K_RESTART = 3'd6;
   localparam logic [2:0] K_STAT = 3'd7;

   localparam logic [3:0] ST_OK = 4'd0;
   localparam logic [3:0] ST_NOTREADY = 4'd1;
   localparam logic [3:0] ST_INVALID = 4'd2;
   localparam logic [3:0] ST_STALE = 4'd3;
   localparam logic [3:0] ST_FUTURE = 4'd4;
   localparam logic [3:0] ST_DEVICE = 4'd5;
   localparam logic [3:0] ST_FULL = 4'd6;
   localparam logic [3:0] ST_REGRESS = 4'd7;
   localparam logic [3:0] ST_NOOP = 4'd8;
   localparam logic [3:0] ST_UPDATED = 4'd9;
   localparam logic [3:0] ST_EMPTY = 4'd10;

   localparam logic [2:0] C_SUBMITTED = 3'd0;
   localparam logic [2:0] C_DISPLAYED = 3'd1;
   localparam logic [2:0] C_STALE = 3'd2;
   localparam logic [2:0] C_FUTURE = 3'd3;
   localparam logic [2:0] C_INVALID = 3'd4;
   localparam logic [2:0] C_DEVICE = 3'd5;
   localparam logic [2:0] C_FULL = 3'd6;
   localparam logic [2:0] C_REGRESS = 3'd7;

   localparam logic [1:0] CSR_CAPACITY = 2'd0;
   localparam logic [1:0] CSR_DEVICE = 2'd1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] gen_tag;
      logic [46:0] frame_number;
      logic [31:0] frame_handle;
      logic        frame_ok;
      logic [15:0] frame_device;
      logic [2:0]  stat_select;
   } item_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       execute;
   } cmd_type;

   typedef struct packed {
      logic take_needs_read;
   } stat_type;

endpackage

// ===== rtl/core/ggfq_ram.sv =====
module ggfq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/ggfq_ctrl.sv =====
module ggfq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  ggfq_pkg::stat_type stat,
   output ggfq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {IDLE, READ, EXEC, HOLD} state_type;
   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd = '0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in = READ;
            end
         end
         READ: begin
            // A take first passes through EXEC so that the head slot read can settle;
            // every other event executes right away.
            if (stat.take_needs_read) begin
               state_in = EXEC;
            end else begin
               cmd.execute = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = HOLD;
            end
         end
         EXEC: begin
            cmd.execute = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = HOLD;
         end
         HOLD: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/ggfq_dp.sv =====
module ggfq_dp (
   input  logic                clock,
   input  logic                reset,
   input  ggfq_pkg::cmd_type   cmd,
   output ggfq_pkg::stat_type  stat,
   input  ggfq_pkg::item_type  item,
   input  logic [4:0]          capacity,
   input  logic [15:0]         expected_device,
   output logic [3:0]          status,
   output logic                out_valid,
   output logic [46:0]         out_frame_number,
   output logic [31:0]         out_frame_generation,
   output logic [31:0]         out_frame_handle,
   output logic [4:0]          queue_depth,
   output logic [31:0]         current_gen,
   output logic [47:0]         shown_frame,
   output logic [47:0]         stat_value
);

   localparam logic [47:0] CntMax = '1;

   ggfq_pkg::item_type           item_ff;
   logic [ggfq_pkg::PtrW-1:0]    head_ff, head_in;
   logic [ggfq_pkg::CntW-1:0]    count_ff, count_in;
   logic [31:0]                  gen_ff, gen_in;
   logic [47:0]                  shown_ff, shown_in;
   logic                         halted_ff, halted_in;
   logic [47:0]                  ctr_ff [8];
   logic [3:0]                   status_ff, status_in;
   logic                         valid_ff, valid_in;
   logic [47:0]                  sval_ff, sval_in;
   logic                         bump;
   logic [2:0]                   bump_idx;
   logic                         wr_en;
   logic [ggfq_pkg::PtrW-1:0]    tail;
   logic [ggfq_pkg::SlotW-1:0]   rd_data;
   logic [ggfq_pkg::CntW-1:0]    cap_use;
   logic [ggfq_pkg::CntW:0]      tail_sum;

   always_comb begin
      if (capacity == 5'd0) begin
         cap_use = ggfq_pkg::CntW'(1);
      end else if ({1'b0, capacity} > 6'(ggfq_pkg::MaxDepth)) begin
         cap_use = ggfq_pkg::CntW'(ggfq_pkg::MaxDepth);
      end else begin
         cap_use = ggfq_pkg::CntW'(capacity);
      end
   end

   assign tail_sum = (ggfq_pkg::CntW+1)'(head_ff) + (ggfq_pkg::CntW+1)'(count_ff);
   assign tail = tail_sum[ggfq_pkg::PtrW-1:0];

   ggfq_ram #(.Width(ggfq_pkg::SlotW), .Depth(ggfq_pkg::MaxDepth)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail),
      .wr_data ({item_ff.gen_tag, item_ff.frame_number, item_ff.frame_handle}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      gen_in = gen_ff;
      shown_in = shown_ff;
      halted_in = halted_ff;
      status_in = ggfq_pkg::ST_OK;
      valid_in = 1'b0;
      sval_in = '0;
      bump = 1'b0;
      bump_idx = ggfq_pkg::C_SUBMITTED;
      wr_en = 1'b0;
      unique case (item_ff.kind)
         ggfq_pkg::K_SUBMIT: begin
            if (halted_ff) begin
               status_in = ggfq_pkg::ST_NOTREADY;
            end else if (!item_ff.frame_ok) begin
               status_in = ggfq_pkg::ST_INVALID;
               bump = 1'b1; bump_idx = ggfq_pkg::C_INVALID;
            end else if (item_ff.gen_tag < gen_ff) begin
               status_in = ggfq_pkg::ST_STALE;
               bump = 1'b1; bump_idx = ggfq_pkg::C_STALE;
            end else if (item_ff.gen_tag > gen_ff) begin
               status_in = ggfq_pkg::ST_FUTURE;
               bump = 1'b1; bump_idx = ggfq_pkg::C_FUTURE;
            end else if (expected_device != 16'd0 &&
                         item_ff.frame_device != expected_device) begin
               status_in = ggfq_pkg::ST_DEVICE;
               bump = 1'b1; bump_idx = ggfq_pkg::C_DEVICE;
            end else if (count_ff >= cap_use) begin
               status_in = ggfq_pkg::ST_FULL;
               bump = 1'b1; bump_idx = ggfq_pkg::C_FULL;
            end else begin
               wr_en = cmd.execute;
               count_in = count_ff + 1'b1;
               bump = 1'b1; bump_idx = ggfq_pkg::C_SUBMITTED;
            end
         end
         ggfq_pkg::K_SETGEN: begin
            if (item_ff.gen_tag < gen_ff) begin
               status_in = ggfq_pkg::ST_REGRESS;
               bump = 1'b1; bump_idx = ggfq_pkg::C_REGRESS;
            end else if (item_ff.gen_tag == gen_ff) begin
               status_in = ggfq_pkg::ST_NOOP;
            end else begin
               status_in = ggfq_pkg::ST_UPDATED;
               gen_in = item_ff.gen_tag;
               head_in = '0;
               count_in = '0;
            end
         end
         ggfq_pkg::K_TAKE: begin
            if (count_ff == '0) begin
               status_in = ggfq_pkg::ST_EMPTY;
            end else begin
               valid_in = 1'b1;
               head_in = head_ff + 1'b1;
               count_in = count_ff - 1'b1;
            end
         end
         ggfq_pkg::K_SHOWN: begin
            shown_in = {1'b0, item_ff.frame_number};
            bump = 1'b1; bump_idx = ggfq_pkg::C_DISPLAYED;
         end
         ggfq_pkg::K_CLEAR: begin
            head_in = '0;
            count_in = '0;
            shown_in = '1;
         end
         ggfq_pkg::K_STOP: begin
            halted_in = 1'b1;
            head_in = '0;
            count_in = '0;
         end
         ggfq_pkg::K_RESTART: halted_in = 1'b0;
         ggfq_pkg::K_STAT: sval_in = ctr_ff[item_ff.stat_select];
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= item;
      end
      if (cmd.execute) begin
         status_ff <= status_in;
         sval_ff <= sval_in;
         if (valid_in) begin
            {out_frame_generation, out_frame_number, out_frame_handle} <= rd_data;
         end else begin
            {out_frame_generation, out_frame_number, out_frame_handle} <= '0;
         end
      end
      if (reset) begin
         head_ff <= '0;
         count_ff <= '0;
         gen_ff <= '0;
         shown_ff <= '1;
         halted_ff <= 1'b0;
         valid_ff <= 1'b0;
         for (int i = 0; i < 8; i++) begin
            ctr_ff[i] <= '0;
         end
      end else if (cmd.execute) begin
         head_ff <= head_in;
         count_ff <= count_in;
         gen_ff <= gen_in;
         shown_ff <= shown_in;
         halted_ff <= halted_in;
         valid_ff <= valid_in;
         if (bump && ctr_ff[bump_idx] != CntMax) begin
            ctr_ff[bump_idx] <= ctr_ff[bump_idx] + 48'd1;
         end
      end
   end

   assign stat.take_needs_read = (item_ff.kind == ggfq_pkg::K_TAKE);
   assign status = status_ff;
   assign out_valid = valid_ff;
   assign queue_depth = 5'(count_ff);
   assign current_gen = gen_ff;
   assign shown_frame = shown_ff;
   assign stat_value = sval_ff;

endmodule

// ===== rtl/core/generation_gated_frame_queue.sv =====
// Frame descriptor queue with admission control. Each request transaction
// carries one event (submit, set generation, take, note displayed, clear,
// stop, restart or counter read) and produces exactly one response
// transaction. The event is captured at the accepting edge and, unless it is
// a take, executed at the next edge, where its response is registered and
// presented. A take passes through an extra EXEC state between capture and
// execution so that the registered read of the head slot in the slot RAM
// settles. The next request is accepted only the cycle after the response to
// the last one is taken. Configuration writes through the CSR port must
// happen while no event is in flight.
module generation_gated_frame_queue (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // kind[2:0], gen_tag[34:3], frame_number[81:35], frame_handle[113:82],
   // frame_ok[114], frame_device[130:115], stat_select[133:131], zero pad.
   input  logic [135:0]  req_tdata,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // status[3:0], out_valid[4], out_frame_number[51:5],
   // out_frame_generation[83:52], out_frame_handle[115:84],
   // queue_depth[120:116], current_gen[152:121], shown_frame[200:153],
   // stat_value[248:201], zero pad.
   output logic [255:0]  rsp_tdata,
   input  logic          csr_psel,
   input  logic          csr_penable,
   input  logic          csr_pwrite,
   input  logic [2:0]    csr_paddr,
   input  logic [31:0]   csr_pwdata,
   output logic [31:0]   csr_prdata,
   output logic          csr_pready
);

   ggfq_pkg::item_type item;
   ggfq_pkg::cmd_type  cmd;
   ggfq_pkg::stat_type stat;
   logic [4:0]         capacity_ff;
   logic [15:0]        device_ff;
   logic [1:0]         reg_idx;
   logic [3:0]         status;
   logic               out_valid;
   logic [46:0]        out_frame_number;
   logic [31:0]        out_frame_generation;
   logic [31:0]        out_frame_handle;
   logic [4:0]         queue_depth;
   logic [31:0]        current_gen;
   logic [47:0]        shown_frame;
   logic [47:0]        stat_value;

   // Unpack the request fields from the lowest bit up.
   assign item.kind = req_tdata[2:0];
   assign item.gen_tag = req_tdata[34:3];
   assign item.frame_number = req_tdata[81:35];
   assign item.frame_handle = req_tdata[113:82];
   assign item.frame_ok = req_tdata[114];
   assign item.frame_device = req_tdata[130:115];
   assign item.stat_select = req_tdata[133:131];

   // Registers sit at word addresses; the low two address bits are ignored.
   assign reg_idx = {1'b0, csr_paddr[2]};
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= 5'd16;
         device_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         unique case (reg_idx)
            ggfq_pkg::CSR_CAPACITY: capacity_ff <= csr_pwdata[4:0];
            ggfq_pkg::CSR_DEVICE: device_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         ggfq_pkg::CSR_CAPACITY: csr_prdata = {27'd0, capacity_ff};
         ggfq_pkg::CSR_DEVICE: csr_prdata = {16'd0, device_ff};
         default: csr_prdata = '0;
      endcase
   end

   ggfq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ggfq_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .stat                 (stat),
      .item                 (item),
      .capacity             (capacity_ff),
      .expected_device      (device_ff),
      .status               (status),
      .out_valid            (out_valid),
      .out_frame_number     (out_frame_number),
      .out_frame_generation (out_frame_generation),
      .out_frame_handle     (out_frame_handle),
      .queue_depth          (queue_depth),
      .current_gen          (current_gen),
      .shown_frame          (shown_frame),
      .stat_value           (stat_value)
   );

   assign rsp_tdata = {7'd0, stat_value, shown_frame, current_gen, queue_depth,
                       out_frame_handle, out_frame_generation, out_frame_number,
                       out_valid, status};

endmodule
